### rtl/core/touch_button_event_detector_assert.svh
// Assertion macros used by the checker of the touch button event detector.
`ifndef TOUCH_BUTTON_EVENT_DETECTOR_ASSERT_SVH
`define TOUCH_BUTTON_EVENT_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TBED_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled while reset is high.
`define TBED_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### rtl/core/tbed_pkg.sv
// ----------------------------------------------------------------------------
// tbed_pkg
// Shared constants and types of the touch button event detector.
// ----------------------------------------------------------------------------
package tbed_pkg;

  localparam int BUTTONS     = 5;
  localparam int TOUCH_PADS  = 4;
  localparam int TIME_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int READ_W   = 16;
  localparam int NOW_W    = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ID_W     = 3;
  localparam int KIND_W   = 2;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] HOLD_RESET = 16'd500;

  // Event kinds.
  localparam logic [KIND_W-1:0] EVT_PRESSED  = 2'd0;
  localparam logic [KIND_W-1:0] EVT_RELEASED = 2'd1;
  localparam logic [KIND_W-1:0] EVT_HELD     = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_UP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_NEXT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd4;

  typedef logic [KIND_W-1:0] kind_t;

  // Events of one poll: a flag per button and the kind of each flagged event.
  typedef struct packed {
    logic [BUTTONS-1:0]  mask;
    kind_t [BUTTONS-1:0] kind;
  } evt_rec_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

### rtl/core/tbed_front.sv
// ----------------------------------------------------------------------------
// tbed_front
// Takes a poll, classifies each button and queues the poll's event set.
// ----------------------------------------------------------------------------
module tbed_front import tbed_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_wr_t              cfg,
  input  logic                 take,
  input  logic [IN_DATA_W-1:0] poll,
  output logic                 push,
  output evt_rec_t             rec
);

  logic [CFG_W-1:0]     baseline [TOUCH_PADS];
  logic [CFG_W-1:0]     hold_ms;
  logic [BUTTONS-1:0]   is_pressed;
  logic [BUTTONS-1:0]   hold_reported;
  logic [TIME_BITS-1:0] press_start [BUTTONS];

  logic [BUTTONS-1:0]   raw_p;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed [BUTTONS];
  logic [BUTTONS-1:0]   hold_due;
  logic [20:0]          lhs [TOUCH_PADS];
  logic [20:0]          rhs [TOUCH_PADS];

  assign now_t = poll[TOUCH_PADS*READ_W+1 +: TIME_BITS];

  // Pad pressed when reading < floor(7*base/10), i.e. 10*reading + 10 <= 7*base.
  always_comb begin
    for (int p = 0; p < TOUCH_PADS; p++) begin
      lhs[p] = {2'b00, poll[p*READ_W +: READ_W], 3'b000}
             + {4'b0000, poll[p*READ_W +: READ_W], 1'b0} + 21'd10;
      rhs[p] = {2'b00, baseline[p], 3'b000} - {5'b00000, baseline[p]};
      raw_p[p] = (lhs[p] <= rhs[p]);
    end
    raw_p[BUTTONS-1] = ~poll[TOUCH_PADS*READ_W];
  end

  always_comb begin
    for (int b = 0; b < BUTTONS; b++) begin
      elapsed[b]  = now_t - press_start[b];
      hold_due[b] = (elapsed[b] >= {{(TIME_BITS-CFG_W){1'b0}}, hold_ms});
      rec.mask[b] = 1'b0;
      rec.kind[b] = EVT_PRESSED;
      if (raw_p[b] && !is_pressed[b]) begin
        rec.mask[b] = 1'b1;
      end else if (!raw_p[b] && is_pressed[b]) begin
        rec.mask[b] = 1'b1;
        rec.kind[b] = EVT_RELEASED;
      end else if (raw_p[b] && !hold_reported[b] && hold_due[b]) begin
        rec.mask[b] = 1'b1;
        rec.kind[b] = EVT_HELD;
      end
    end
  end

  assign push = take && (rec.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < TOUCH_PADS; p++) begin
        baseline[p] <= '0;
      end
      hold_ms <= HOLD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BASE_UP:   baseline[0] <= cfg.data;
        CFG_BASE_DOWN: baseline[1] <= cfg.data;
        CFG_BASE_NEXT: baseline[2] <= cfg.data;
        CFG_BASE_BACK: baseline[3] <= cfg.data;
        CFG_HOLD:      hold_ms     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed    <= '0;
      hold_reported <= '0;
    end else if (take) begin
      for (int b = 0; b < BUTTONS; b++) begin
        if (raw_p[b] && !is_pressed[b]) begin
          is_pressed[b]    <= 1'b1;
          hold_reported[b] <= 1'b0;
        end else if (!raw_p[b] && is_pressed[b]) begin
          is_pressed[b] <= 1'b0;
        end else if (raw_p[b] && !hold_reported[b] && hold_due[b]) begin
          hold_reported[b] <= 1'b1;
        end
      end
    end
  end

  // Start time is only read while the button is pressed.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int b = 0; b < BUTTONS; b++) begin
        if (raw_p[b] && !is_pressed[b]) begin
          press_start[b] <= now_t;
        end
      end
    end
  end

endmodule

### rtl/core/tbed_queue.sv
// ----------------------------------------------------------------------------
// tbed_queue
// Small first-in first-out queue of per-poll event sets.
// ----------------------------------------------------------------------------
module tbed_queue import tbed_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  evt_rec_t wr_rec,
  input  logic     pop,
  output logic     full,
  output logic     nonempty,
  output evt_rec_t rd_rec
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  evt_rec_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_rec   = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

endmodule

### rtl/core/tbed_back.sv
// ----------------------------------------------------------------------------
// tbed_back
// Serializes queued event sets into events, one per cycle while out_ready.
// ----------------------------------------------------------------------------
module tbed_back import tbed_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  evt_rec_t              q_rec,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [KIND_W-1:0]     out_user,
  output logic                  out_last
);

  logic [BUTTONS-1:0]  rec_mask;
  kind_t [BUTTONS-1:0] rec_kind;
  evt_rec_t            cur;
  logic                rec_busy;
  logic                can_load;
  logic                load;
  logic [ID_W-1:0]     sel;
  logic [BUTTONS-1:0]  sel_bit;
  logic [BUTTONS-1:0]  rest;

  assign rec_busy = (rec_mask != '0);
  assign cur.mask = rec_busy ? rec_mask : q_rec.mask;
  assign cur.kind = rec_busy ? rec_kind : q_rec.kind;
  assign can_load = !out_valid || out_ready;
  assign load     = can_load && (rec_busy || q_valid);
  assign q_pop    = load && !rec_busy;

  // Lowest pending button goes first.
  always_comb begin
    sel     = '0;
    sel_bit = '0;
    for (int b = BUTTONS - 1; b >= 0; b--) begin
      if (cur.mask[b]) begin
        sel     = ID_W'(b);
        sel_bit = BUTTONS'(1) << b;
      end
    end
    rest = cur.mask & ~sel_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_mask  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rec_mask  <= rest;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_kind <= cur.kind;
      out_data <= {{(OUT_DATA_W-ID_W){1'b0}}, sel};
      out_user <= cur.kind[sel];
      out_last <= (rest == '0);
    end
  end

endmodule

### rtl/core/touch_button_event_detector.sv
// A taken poll's event set passes the queue, then the registered output stage.
// A poll can be accepted every cycle while the queue has room; events leave at one
// per cycle while out_tready is high, and a poll makes 0 to 5 events.
// The event-set queue (QUEUE_DEPTH polls) absorbs bursts; input stalls when full.
// Synchronous active-high reset clears button state, queue and output; baselines
// return to 0 and the hold time to 500 ms.
// ----------------------------------------------------------------------------
// touch_button_event_detector
// Press, release and hold detection for four touch pads and one push button.
// ----------------------------------------------------------------------------
module touch_button_event_detector import tbed_pkg::*; #(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Poll stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, low bit up: touch_up[15:0], touch_down[31:16], touch_next[47:32],
  // touch_back[63:48], play_level[64], now_ms[96:65], zero fill [103:97].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Event stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, low bit up: button_id[2:0], zero fill [7:3].
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: event_kind[1:0].
  output logic [KIND_W-1:0]     out_tuser,
  // out_tlast: set on the final event of a poll.
  output logic                  out_tlast,
  // Register write channel; always ready.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_wr_t  cfg;
  evt_rec_t front_rec;
  evt_rec_t head_rec;
  logic     take;
  logic     push;
  logic     q_full;
  logic     q_nonempty;
  logic     q_pop;

  // Registers are written whenever the write channel presents a transfer.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // A poll transfer is taken whenever the queue has room for its event set.
  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  // The front classifies every button in the cycle of the transfer and
  // pushes the set of resulting events; polls without events push nothing.
  tbed_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .poll (in_tdata),
    .push (push),
    .rec  (front_rec)
  );

  tbed_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_rec   (front_rec),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rd_rec   (head_rec)
  );

  // The back walks each event set in button order through a registered
  // output stage, so results wait there while the queue takes sets until full.
  tbed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_rec     (head_rec),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

### rtl/core/tbed_checker.sv
// ----------------------------------------------------------------------------
// tbed_checker
// Port-level checks of the touch button event detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "touch_button_event_detector_assert.svh"

module tbed_checker import tbed_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]     out_tuser,
  input logic                  out_tlast
);

  // A stalled event holds its contents.
  `TBED_ASSERT_NEXT(a_out_hold, clk, rst, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // Events of one poll leave without gaps until the last one.
  `TBED_ASSERT_NEXT(a_run_dense, clk, rst, out_tvalid && out_tready && !out_tlast,
    out_tvalid)

  // Right after reset nothing is pending and polls are taken.
  `TBED_ASSERT_SAME(a_reset_idle, clk, rst, $past(rst), !out_tvalid && in_tready)

endmodule

bind touch_button_event_detector tbed_checker u_tbed_checker (
  .clk        (clk),
  .rst        (rst),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### sim/touch_button_event_detector_tb.sv
// ----------------------------------------------------------------------------
// touch_button_event_detector_tb
// Self-checking bench for the touch button event detector. Polls go in on the
// input stream, and a model in the bench tracks the press, release and hold
// state of each button and queues the events that each poll should produce.
// Every event transfer on the output stream is checked against the oldest
// queued event. Directed polls cover the edge cases and random polls cover the
// rest. Random idling runs on both sides, and one long output stall backs the
// design up to its input.
// ----------------------------------------------------------------------------
module touch_button_event_detector_tb import tbed_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Touch threshold is floor(baseline * 7 / 10).
  localparam int THRESH_NUM     = 7;
  localparam int THRESH_DEN     = 10;
  localparam int TIME_W         = TIME_BITS_DEF;
  localparam int RESET_CYCLES   = 11;
  // Each poll's events pass the design's queue and registered output stage. This
  // margin is well past that, so a poll that makes no event is finished too.
  localparam int SETTLE_CYCLES  = 12;
  localparam int RX_HOLD_CYCLES = 300;
  // The longest correct stretch with no transfer is the long output stall.
  localparam int WATCHDOG_LIMIT = 4000;

  // One poll. Packed so that touch_up lands in the lowest bits, which is
  // the in_tdata layout.
  typedef struct packed {
    logic [NOW_W-1:0]                   now_ms;
    logic                               play_level;
    logic [TOUCH_PADS-1:0][READ_W-1:0]  touch;
  } poll_t;

  typedef struct packed {
    logic              last;
    kind_t             kind;
    logic [ID_W-1:0]   id;
  } btn_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Model copy of the registers and of the per-button state.
  logic [CFG_W-1:0]  base_reg [TOUCH_PADS];
  logic [CFG_W-1:0]  hold_reg;
  logic              btn_pressed [BUTTONS];
  logic [TIME_W-1:0] btn_since [BUTTONS];
  logic              btn_held [BUTTONS];

  // Events still owed by the design, oldest first.
  btn_event_t pending_events [$];
  int         fail_cnt = 0;

  // Idling controls. The sender percentage is only read by the stimulus
  // process. The receiver percentage and the stall request are read by the
  // receiver process, so the stimulus updates them with nonblocking writes.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_hold_start = 1'b0;
  int   rx_hold_left = 0;
  int   idle_cycles = 0;

  // State of the random poll generator: whether a finger is on each button,
  // and the running clock in milliseconds.
  logic              finger [BUTTONS];
  logic [NOW_W-1:0]  t_now;

  touch_button_event_detector dut (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model of the detector.
  // ---------------------------------------------------------------------------

  function automatic int pad_threshold(input int pad);
    return (int'(base_reg[pad]) * THRESH_NUM) / THRESH_DEN;
  endfunction

  // Updates the button state for one accepted poll and queues the events that
  // it causes, in button order, with last set on the final one.
  task automatic predict_button_events(input poll_t p);
    btn_event_t        evs [$];
    logic              hit;
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] elapsed;
    now_t = TIME_W'(p.now_ms);
    for (int b = 0; b < BUTTONS; b++) begin
      if (b < TOUCH_PADS) begin
        hit = int'(p.touch[b]) < pad_threshold(b);
      end else begin
        hit = (p.play_level == 1'b0);
      end
      if (hit && !btn_pressed[b]) begin
        btn_pressed[b] = 1'b1;
        btn_since[b]   = now_t;
        btn_held[b]    = 1'b0;
        evs.push_back('{last: 1'b0, kind: EVT_PRESSED, id: ID_W'(b)});
      end else if (!hit && btn_pressed[b]) begin
        // The hold flag stays as it is; the next press clears it.
        btn_pressed[b] = 1'b0;
        evs.push_back('{last: 1'b0, kind: EVT_RELEASED, id: ID_W'(b)});
      end else if (hit && !btn_held[b]) begin
        // Elapsed time wraps with the timer width.
        elapsed = now_t - btn_since[b];
        if (elapsed >= TIME_W'(hold_reg)) begin
          btn_held[b] = 1'b1;
          evs.push_back('{last: 1'b0, kind: EVT_HELD, id: ID_W'(b)});
        end
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Shared drivers.
  // ---------------------------------------------------------------------------

  // Offers one poll and waits for its transfer. The valid is left high, so
  // back-to-back polls keep it asserted. The next call or settle() decides
  // whether it drops.
  task automatic send_poll(input poll_t p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(p);
    do @(posedge clk); while (!in_tready);
    predict_button_events(p);
  endtask

  // Stops sending, waits until every owed event has arrived, then gives the
  // pipeline time to retire polls that produce no event.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register and mirrors it in the model. Indexes past the hold
  // register do not exist, so the design and the model both ignore them.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HOLD) begin
      hold_reg = val;
    end else if (idx <= CFG_BASE_BACK) begin
      base_reg[idx] = val;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_baselines(input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] down,
                               input logic [CFG_W-1:0] nxt, input logic [CFG_W-1:0] back);
    write_reg(CFG_BASE_UP, up);
    write_reg(CFG_BASE_DOWN, down);
    write_reg(CFG_BASE_NEXT, nxt);
    write_reg(CFG_BASE_BACK, back);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  function automatic poll_t make_poll(input logic [READ_W-1:0] up, input logic [READ_W-1:0] down,
                                      input logic [READ_W-1:0] nxt, input logic [READ_W-1:0] back,
                                      input logic play, input logic [NOW_W-1:0] now);
    poll_t p;
    p.touch[0]   = up;
    p.touch[1]   = down;
    p.touch[2]   = nxt;
    p.touch[3]   = back;
    p.play_level = play;
    p.now_ms     = now;
    return p;
  endfunction

  // Builds a plausible poll. Fingers stay on or off for several polls, so
  // presses last long enough to reach the hold time. Some readings, levels
  // and times are pure noise so that every bit sees both values.
  function automatic poll_t rand_poll();
    poll_t p;
    int    thr;
    for (int b = 0; b < BUTTONS; b++) begin
      if ($urandom_range(0, 99) < 20) finger[b] = ~finger[b];
    end
    case ($urandom_range(0, 15))
      0:       t_now = $urandom();
      1:       t_now = t_now + NOW_W'(hold_reg);
      2:       t_now = t_now + NOW_W'(hold_reg) - 1;
      default: t_now = t_now + NOW_W'($urandom_range(0, int'(hold_reg) / 3 + 2));
    endcase
    for (int b = 0; b < TOUCH_PADS; b++) begin
      thr = pad_threshold(b);
      if ($urandom_range(0, 4) == 0) begin
        p.touch[b] = READ_W'($urandom_range(0, 65535));
      end else if (finger[b] && thr > 0) begin
        p.touch[b] = READ_W'($urandom_range(0, thr - 1));
      end else begin
        p.touch[b] = READ_W'($urandom_range(thr, 65535));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      p.play_level = 1'($urandom_range(0, 1));
    end else begin
      p.play_level = ~finger[TOUCH_PADS];
    end
    p.now_ms = t_now;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog.
  // ---------------------------------------------------------------------------

  // The ready line idles at random, except during a requested long stall.
  // The stall length is counted here.
  always @(posedge clk) begin
    if (rx_hold_start) begin
      rx_hold_left <= RX_HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every event transfer is compared field by field with the oldest owed
  // event.
  always @(posedge clk) begin : check_events
    btn_event_t want;
    if (!rst && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("event with none expected: button_id %0d event_kind %0d last %0b",
               out_tdata[ID_W-1:0], out_tuser, out_tlast);
        fail_cnt++;
      end else begin
        want = pending_events.pop_front();
        if (out_tdata[ID_W-1:0] !== want.id) begin
          $error("button_id: expected %0d, got %0d", want.id, out_tdata[ID_W-1:0]);
          fail_cnt++;
        end
        if (out_tuser !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_tuser);
          fail_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          fail_cnt++;
        end
        if (out_tdata[OUT_DATA_W-1:ID_W] !== '0) begin
          $error("tdata fill: expected 0, got %0h", out_tdata[OUT_DATA_W-1:ID_W]);
          fail_cnt++;
        end
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("touch_button_event_detector: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values: zero baselines keep every pad released even at a zero
  // reading. The play button still works, with the default 500 ms hold.
  task automatic test_reset_defaults();
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd1000));
    send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd1000));
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd1499));
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd1500));
    // Held is reported once per press.
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd9999));
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd10000));
    settle();
  endtask

  // Every register plus the unused indexes, which must change nothing. The
  // thresholds are hit exactly at their edges: 45874 for a full baseline,
  // 7 for a baseline of 10, and 0 for baselines of 1 and 0.
  task automatic test_register_map();
    set_baselines(16'hFFFF, 16'd10, 16'd1, 16'd0);
    write_reg(CFG_HOLD, 16'd0);
    for (int i = CFG_HOLD + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 16'hA5A5);
    end
    send_poll(make_poll(16'd45873, 16'd6, 16'd0, 16'd0, 1'b0, 32'hFFFF_FFF0));
    // With a zero hold time, held still waits for the poll after the press.
    send_poll(make_poll(16'd45874, 16'd7, 16'd0, 16'd0, 1'b0, 32'hFFFF_FFF0));
    send_poll(make_poll(16'd45874, 16'd7, 16'd0, 16'd0, 1'b1, 32'hFFFF_FFF1));
    settle();
  endtask

  // Hold timing across the wrap of the millisecond counter, then all five
  // buttons at once at the longest hold, including a second press after a
  // release, which must report held again.
  task automatic test_hold_and_wrap();
    write_reg(CFG_HOLD, 16'd32);
    send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFF0));
    send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0000_000F));
    send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0000_0010));
    send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0000_0011));
    settle();
    set_baselines(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_HOLD, 16'hFFFF);
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0));
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd65534));
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd65535));
    send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'd70000));
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd100000));
    send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd165535));
    send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'd165536));
    settle();
  endtask

  // Random polls under a fresh random setting. Baselines and the hold time
  // are sometimes forced to their extremes.
  task automatic test_random_polls(input int n_polls);
    logic [CFG_W-1:0] base [TOUCH_PADS];
    for (int i = 0; i < TOUCH_PADS; i++) begin
      case ($urandom_range(0, 5))
        0:       base[i] = '0;
        1:       base[i] = '1;
        default: base[i] = CFG_W'($urandom_range(0, 65535));
      endcase
    end
    set_baselines(base[0], base[1], base[2], base[3]);
    case ($urandom_range(0, 3))
      0:       write_reg(CFG_HOLD, 16'd0);
      1:       write_reg(CFG_HOLD, CFG_W'($urandom_range(1, 50)));
      2:       write_reg(CFG_HOLD, CFG_W'($urandom_range(0, 65535)));
      default: write_reg(CFG_HOLD, 16'hFFFF);
    endcase
    for (int b = 0; b < BUTTONS; b++) finger[b] = 1'($urandom_range(0, 1));
    t_now = $urandom();
    repeat (n_polls) send_poll(rand_poll());
    settle();
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering
  // polls that each make five events. The event queue fills and the input
  // must stall until the receiver resumes.
  task automatic test_output_backpressure();
    set_baselines(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    rx_hold_start <= 1'b1;
    @(posedge clk);
    rx_hold_start <= 1'b0;
    for (int i = 0; i < 24; i++) begin
      if (i % 2 == 0) begin
        send_poll(make_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, NOW_W'(i * 7)));
      end else begin
        send_poll(make_poll(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NOW_W'(i * 7)));
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < TOUCH_PADS; i++) base_reg[i] = '0;
    hold_reg = HOLD_RESET;
    for (int b = 0; b < BUTTONS; b++) begin
      btn_pressed[b] = 1'b0;
      btn_since[b]   = '0;
      btn_held[b]    = 1'b0;
      finger[b]      = 1'b0;
    end
    t_now = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles rarely and receiver often, then the reverse, then neither.
    set_idling(17, 81);
    test_reset_defaults();
    test_register_map();
    test_hold_and_wrap();
    test_random_polls(35);
    set_idling(81, 17);
    test_random_polls(35);
    set_idling(0, 0);
    test_random_polls(35);
    test_output_backpressure();

    settle();
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("touch_button_event_detector: match");
    end else begin
      $display("touch_button_event_detector: mismatch");
    end
    $finish;
  end

endmodule
